### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, clocked on aclk and quiet while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VAHD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VAHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/vahd_pkg.sv
// ----------------------------------------------------------------------------
// vahd_pkg
// types, constants and helpers shared by the voice activity detector
// ----------------------------------------------------------------------------
`default_nettype none

package vahd_pkg;

    localparam logic [15:0] TICK_MS  = 16'd50;
    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    localparam logic [15:0] RST_START_TH   = 16'd29491;
    localparam logic [15:0] RST_STOP_TH    = 16'd16384;
    localparam logic [15:0] RST_SILENCE_MS = 16'd800;
    localparam logic [15:0] RST_MIN_MS     = 16'd300;
    localparam logic [15:0] RST_MAX_MS     = 16'd8000;
    localparam logic [17:0] RST_BUF_LIMIT  = 18'd128000;
    localparam logic [17:0] RST_MIN_SAMP   = 18'd1600;

    localparam int unsigned ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_START_TH   = 3'd0,
        REG_STOP_TH    = 3'd1,
        REG_SILENCE_MS = 3'd2,
        REG_MIN_MS     = 3'd3,
        REG_MAX_MS     = 3'd4,
        REG_BUF_LIMIT  = 3'd5,
        REG_MIN_SAMP   = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_SILENCE   = 2'd0,
        PH_CANDIDATE = 2'd1,
        PH_SPEAKING  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [15:0] start_threshold;
        logic [15:0] stop_threshold;
        logic [15:0] silence_limit_ms;
        logic [15:0] min_speech_ms;
        logic [15:0] max_speech_ms;
        logic [17:0] buffer_limit;
        logic [17:0] min_samples;
    } cfg_t;

    typedef struct packed {
        logic        capture_ready;
        logic [15:0] amplitude;
        logic [11:0] samples_read;
        logic        recognizer_ready;
    } item_t;

    typedef struct packed {
        logic [1:0]  detector_state;
        logic        speech_started;
        logic        speech_ended;
        logic [17:0] captured_samples;
        logic        run_recognizer;
    } result_t;

    // add one tick to a millisecond counter, saturating
    function automatic logic [15:0] tick_add(input logic [15:0] t);
        logic [16:0] s;
        s = {1'b0, t} + {1'b0, TICK_MS};
        return s[16] ? TIME_MAX : s[15:0];
    endfunction

endpackage

`default_nettype wire

### hdl/voice_activity_hysteresis_detector_top.sv
// ----------------------------------------------------------------------------
// voice_activity_hysteresis_detector_top
// energy threshold voice activity detector with hysteresis
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one transaction per 50 ms tick (ready flags, rms amplitude,
//   sample count). m_ channel: exactly one result transaction per tick
//   (phase after the tick, start/end pulses, captured count, recognizer
//   request). apb port: seven 32-bit registers at byte offsets 0..24.
//   flow: an accepted tick waits in the input register, then its result
//   is registered in the output register and presented on m_.
//   throughput: one tick per cycle while m_tready holds high, set by the single
//   registered pass through the state machine between input and output registers.
//   reset (aresetn low, synchronous): registers to defaults, phase to
//   silence, counters cleared, both pipeline stages emptied.
//   receiver stall: the output register holds its result, the input
//   register still takes one more tick, then s_tready drops until m_tready
//   returns; nothing is dropped or repeated.
//   the user must write configuration while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module voice_activity_hysteresis_detector_top
    import vahd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // apb configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // tick input
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // capture_ready[0], amplitude[16:1], samples_read[28:17],
    // recognizer_ready[29], zero[31:30]
    input  wire logic [31:0]       s_tdata,
    // result output
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // detector_state[1:0], speech_started[2], speech_ended[3],
    // captured_samples[21:4], run_recognizer[22], zero[23]
    output logic      [23:0]       m_tdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    in_valid_reg, in_valid_next;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    in_take;
    logic    advance;
    logic    fire;

    // register file
    vahd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // output stage frees up when empty or being drained this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    // input stage takes a tick when empty or moving on
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // unpack the input transaction
    always_comb begin
        in_item_next.capture_ready    = s_tdata[0];
        in_item_next.amplitude        = s_tdata[16:1];
        in_item_next.samples_read     = s_tdata[28:17];
        in_item_next.recognizer_ready = s_tdata[29];
    end

    always_comb begin
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // state machine: state updates on fire, result is combinational
    vahd_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item_reg),
        .fire    (fire),
        .res     (res)
    );

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= in_item_next;
        end
        if (fire) begin
            out_res_reg <= res;
        end
    end

    // pack the result transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.run_recognizer,
                       out_res_reg.captured_samples,
                       out_res_reg.speech_ended,
                       out_res_reg.speech_started,
                       out_res_reg.detector_state};

    // a segment cannot start and end on the same tick
    `VAHD_ASSERT(a_no_start_and_end, m_tvalid, !(m_tdata[2] && m_tdata[3]), "start and end together")
    // recognition only requested on an end tick
    `VAHD_ASSERT(a_run_needs_end, m_tvalid && m_tdata[22], m_tdata[3], "run without end")
    // an ended segment leaves the detector in silence
    `VAHD_ASSERT(a_end_to_silence, m_tvalid && m_tdata[3], m_tdata[1:0] == PH_SILENCE, "end not silence")
    // a processed tick always lands in the output register
    `VAHD_ASSERT_NEXT(a_fire_gives_out, fire, out_valid_reg, "result lost")

endmodule

`default_nettype wire

### hdl/vahd_regs.sv
// ----------------------------------------------------------------------------
// vahd_regs
// apb configuration register file
// ----------------------------------------------------------------------------
`default_nettype none

module vahd_regs
    import vahd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_START_TH:   cfg_next.start_threshold  = pwdata[15:0];
                REG_STOP_TH:    cfg_next.stop_threshold   = pwdata[15:0];
                REG_SILENCE_MS: cfg_next.silence_limit_ms = pwdata[15:0];
                REG_MIN_MS:     cfg_next.min_speech_ms    = pwdata[15:0];
                REG_MAX_MS:     cfg_next.max_speech_ms    = pwdata[15:0];
                REG_BUF_LIMIT:  cfg_next.buffer_limit     = pwdata[17:0];
                REG_MIN_SAMP:   cfg_next.min_samples      = pwdata[17:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_threshold  <= RST_START_TH;
            cfg_reg.stop_threshold   <= RST_STOP_TH;
            cfg_reg.silence_limit_ms <= RST_SILENCE_MS;
            cfg_reg.min_speech_ms    <= RST_MIN_MS;
            cfg_reg.max_speech_ms    <= RST_MAX_MS;
            cfg_reg.buffer_limit     <= RST_BUF_LIMIT;
            cfg_reg.min_samples      <= RST_MIN_SAMP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_START_TH:   prdata = {16'd0, cfg_reg.start_threshold};
            REG_STOP_TH:    prdata = {16'd0, cfg_reg.stop_threshold};
            REG_SILENCE_MS: prdata = {16'd0, cfg_reg.silence_limit_ms};
            REG_MIN_MS:     prdata = {16'd0, cfg_reg.min_speech_ms};
            REG_MAX_MS:     prdata = {16'd0, cfg_reg.max_speech_ms};
            REG_BUF_LIMIT:  prdata = {14'd0, cfg_reg.buffer_limit};
            REG_MIN_SAMP:   prdata = {14'd0, cfg_reg.min_samples};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/vahd_fsm.sv
// ----------------------------------------------------------------------------
// vahd_fsm
// detector state machine with duration and sample counters
// ----------------------------------------------------------------------------
`default_nettype none

module vahd_fsm
    import vahd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire item_t item,
    input  wire logic  fire,
    output result_t    res
);

    phase_t      phase_reg,   phase_next;
    logic [15:0] speech_reg,  speech_next;
    logic [15:0] silence_reg, silence_next;
    logic [17:0] total_reg,   total_next;

    logic [15:0] speech_inc;
    logic [15:0] silence_inc;
    logic [18:0] sum_wide;
    logic [17:0] total_add;
    logic        above_start;
    logic        above_stop;
    logic        confirm;
    logic        seg_end;

    // shared datapath terms
    always_comb begin
        speech_inc  = tick_add(speech_reg);
        above_start = item.amplitude > cfg.start_threshold;
        above_stop  = item.amplitude > cfg.stop_threshold;
        silence_inc = above_stop ? 16'd0 : tick_add(silence_reg);
        sum_wide    = {1'b0, total_reg} + {7'd0, item.samples_read};
        if (total_reg < cfg.buffer_limit) begin
            total_add = (sum_wide > {1'b0, cfg.buffer_limit}) ? cfg.buffer_limit
                                                                : sum_wide[17:0];
        end else begin
            total_add = total_reg;
        end
        confirm = above_start && (speech_inc >= cfg.min_speech_ms);
        seg_end = (silence_inc >= cfg.silence_limit_ms) ||
                  (speech_inc >= cfg.max_speech_ms) ||
                  (total_add >= cfg.buffer_limit);
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (item.capture_ready) begin
            case (phase_reg)
                PH_CANDIDATE: begin
                    if (!above_start) begin
                        phase_next = PH_SILENCE;
                    end else if (confirm) begin
                        phase_next = PH_SPEAKING;
                    end
                end
                PH_SPEAKING: begin
                    if (seg_end) begin
                        phase_next = PH_SILENCE;
                    end
                end
                default: begin
                    phase_next = above_start ? PH_CANDIDATE : PH_SILENCE;
                end
            endcase
        end
    end

    // counters and result
    always_comb begin
        speech_next  = speech_reg;
        silence_next = silence_reg;
        total_next   = total_reg;
        res.detector_state   = phase_next;
        res.speech_started   = 1'b0;
        res.speech_ended     = 1'b0;
        res.captured_samples = 18'd0;
        res.run_recognizer   = 1'b0;
        if (item.capture_ready) begin
            case (phase_reg)
                PH_CANDIDATE: begin
                    speech_next = speech_inc;
                    if (above_start && confirm) begin
                        silence_next       = 16'd0;
                        total_next         = 18'd0;
                        res.speech_started = 1'b1;
                    end
                end
                PH_SPEAKING: begin
                    speech_next  = speech_inc;
                    silence_next = silence_inc;
                    total_next   = total_add;
                    if (seg_end) begin
                        res.speech_ended     = 1'b1;
                        res.captured_samples = total_add;
                        res.run_recognizer   = (total_add >= cfg.min_samples) &&
                                               item.recognizer_ready;
                        speech_next  = 16'd0;
                        silence_next = 16'd0;
                        total_next   = 18'd0;
                    end
                end
                default: begin
                    if (above_start) begin
                        speech_next = 16'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SILENCE;
            speech_reg  <= 16'd0;
            silence_reg <= 16'd0;
            total_reg   <= 18'd0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            speech_reg  <= speech_next;
            silence_reg <= silence_next;
            total_reg   <= total_next;
        end
    end

endmodule

`default_nettype wire
